// ----- sv/rau_pkg.sv -----
// Package: shared constants, types and codes for the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;
	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int RESULT_WIDTH = 33;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ZERO_DEN = 2'd1,
		STAT_DIV_ZERO = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// ----- sv/rau_divider.sv -----
// Shared restoring divider: one quotient bit per cycle, unsigned.
`timescale 1ns / 1ps
module rau_divider #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output rau_pkg::div_ctl_t ctl,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0]  quo_q, rem_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [W:0]    trial;
	logic [W:0]    diff;

	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start  = start;
	assign ctl.busy   = busy_q;
	assign ctl.done   = done_q;
	assign quotient   = quo_q;
	assign remainder  = rem_q;
endmodule

// ----- sv/rational_arithmetic_unit.sv -----
// Rational arithmetic unit: cross products, Euclid GCD and reduction.
// Errors go straight to done; otherwise cross products, k Euclid remainder
// steps and two reductions, all divisions PW = 2*OPERAND_WIDTH + 1 bits wide.
// All divisions share one bit-serial divider, one quotient bit per cycle.
// One request at a time; ready again in the cycle after the result is taken.
// Asynchronous active-low reset returns the sequencer to idle.
`timescale 1ns / 1ps
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic signed [15:0] first_numerator,
	input  logic signed [15:0] first_denominator,
	input  logic signed [15:0] second_numerator,
	input  logic signed [15:0] second_denominator,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [32:0] result_numerator,
	output logic signed [32:0] result_denominator,
	output logic [1:0]  status
);
	localparam int OW = OPERAND_WIDTH;
	localparam int PW = 2 * OW + 1;
	localparam int RW = rau_pkg::RESULT_WIDTH;

	rau_pkg::state_t st_q, st_d;
	logic [OW-1:0] pm_q, qm_q, rm_q, sm_q;
	logic          pn_q, qn_q, rn_q, sn_q;
	rau_pkg::func_t fn_q;
	logic [PW-1:0] nm_q, dm_q, x_q, y_q;
	logic          nn_q, dn_q, par_q, cmp_q;
	logic [PW-1:0] nq_q;
	logic [RW-1:0] rn_out_q, rd_out_q;
	logic [1:0]    stat_q;
	logic          ov_q;

	function automatic logic [OW:0] mag_of(input logic [15:0] raw);
		logic [OW-1:0] v;
		begin
			v = OW'(raw);
			if (v[OW-1]) mag_of = {1'b1, OW'(-v)};
			else mag_of = {1'b0, v};
		end
	endfunction

	function automatic logic [RW-1:0] to_out(input logic neg, input logic [PW-1:0] m);
		logic [RW+PW-1:0] v;
		begin
			v = {{RW{1'b0}}, m};
			if (neg) v = -v;
			to_out = v[RW-1:0];
		end
	endfunction

	function automatic logic [PW-1:0] umul(input logic [OW:0] a, input logic [OW:0] b);
		logic [2*OW+1:0] w;
		begin
			w = {{(OW+1){1'b0}}, a} * {{(OW+1){1'b0}}, b};
			umul = w[PW-1:0];
		end
	endfunction

	// Magnitudes stored with OW bits; a most negative value's magnitude still fits.
	logic [OW:0] a_p, a_q, a_r, a_s;
	assign a_p = mag_of(first_numerator);
	assign a_q = mag_of(first_denominator);
	assign a_r = mag_of(second_numerator);
	assign a_s = mag_of(second_denominator);

	function automatic logic [OW:0] full_mag(input logic [OW-1:0] m, input logic n);
		full_mag = (n && m == '0) ? {1'b1, {OW{1'b0}}} : {1'b0, m};
	endfunction

	logic [OW:0] fp, fq, fr, fs;
	assign fp = full_mag(pm_q, pn_q);
	assign fq = full_mag(qm_q, qn_q);
	assign fr = full_mag(rm_q, rn_q);
	assign fs = full_mag(sm_q, sn_q);

	// Cross products, registered before the add.
	logic [PW-1:0] ps_m, rq_m, pr_m, qs_m, qr_m;
	logic [PW-1:0] m1_s1, m2_s1, m3_s1;
	logic          n1_s1, n2_s1, n3_s1;
	assign ps_m = umul(fp, fs);
	assign rq_m = umul(fr, fq);
	assign pr_m = umul(fp, fr);
	assign qs_m = umul(fq, fs);
	assign qr_m = umul(fq, fr);

	logic [PW-1:0] sum_m;
	logic          sum_n;
	always_comb begin
		if (n1_s1 == n2_s1) begin
			sum_m = m1_s1 + m2_s1;
			sum_n = n1_s1;
		end else if (m1_s1 >= m2_s1) begin
			sum_m = m1_s1 - m2_s1;
			sum_n = n1_s1;
		end else begin
			sum_m = m2_s1 - m1_s1;
			sum_n = n2_s1;
		end
		if (sum_m == '0) sum_n = 1'b0;
	end

	rau_pkg::div_ctl_t dctl;
	logic          dstart;
	logic [PW-1:0] ddvd, ddvs, dquo, drem;

	rau_divider #(.W(PW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.dividend(ddvd), .divisor(ddvs),
		.ctl(dctl), .quotient(dquo), .remainder(drem)
	);

	logic gneg;
	assign gneg = par_q ? dn_q : nn_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			rau_pkg::ST_IDLE: if (in_valid) begin
				if (a_q[OW-1:0] == '0 && !a_q[OW]) st_d = rau_pkg::ST_DONE;
				else if (a_s[OW-1:0] == '0 && !a_s[OW]) st_d = rau_pkg::ST_DONE;
				else if (func == rau_pkg::FUNC_DIV && a_r == '0) st_d = rau_pkg::ST_DONE;
				else st_d = rau_pkg::ST_MUL;
			end
			rau_pkg::ST_MUL: st_d = rau_pkg::ST_GCD;
			rau_pkg::ST_GCD: if (!cmp_q && !dctl.busy && m3_s1 == '0) begin
				if (y_q == '0) st_d = rau_pkg::ST_DIVN;
			end
			rau_pkg::ST_DIVN: if (dctl.done) st_d = rau_pkg::ST_DIVD;
			rau_pkg::ST_DIVD: if (dctl.done) st_d = rau_pkg::ST_DONE;
			rau_pkg::ST_DONE: if (out_ready && ov_q) st_d = rau_pkg::ST_IDLE;
			default: st_d = rau_pkg::ST_IDLE;
		endcase
	end

	// Divider launches: GCD step while y != 0, then the two reductions.
	always_comb begin
		dstart = 1'b0;
		ddvd   = x_q;
		ddvs   = y_q;
		unique case (st_q)
			rau_pkg::ST_GCD: dstart = !cmp_q && !dctl.busy && m3_s1 == '0 && y_q != '0;
			rau_pkg::ST_DIVN: begin
				ddvd   = nm_q;
				ddvs   = x_q;
				dstart = cmp_q;
			end
			rau_pkg::ST_DIVD: begin
				ddvd   = dm_q;
				ddvs   = x_q;
				dstart = cmp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= rau_pkg::ST_IDLE;
			ov_q  <= 1'b0;
			cmp_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == rau_pkg::ST_DONE && out_ready && ov_q) ov_q <= 1'b0;
			else if (st_q != rau_pkg::ST_DONE && st_d == rau_pkg::ST_DONE) ov_q <= 1'b1;
			// cmp_q: a division result is pending collection / first cycle of stage
			if (st_q != st_d) cmp_q <= (st_d == rau_pkg::ST_DIVN || st_d == rau_pkg::ST_DIVD);
			else if (dstart) cmp_q <= (st_q == rau_pkg::ST_GCD);
			else if (dctl.done) cmp_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			rau_pkg::ST_IDLE: if (in_valid) begin
				pm_q <= a_p[OW-1:0]; pn_q <= a_p[OW];
				qm_q <= a_q[OW-1:0]; qn_q <= a_q[OW];
				rm_q <= a_r[OW-1:0]; rn_q <= a_r[OW];
				sm_q <= a_s[OW-1:0]; sn_q <= a_s[OW];
				fn_q <= rau_pkg::func_t'(func);
				rn_out_q <= '0;
				rd_out_q <= '0;
				if ((a_q == '0) || (a_s == '0)) stat_q <= rau_pkg::STAT_ZERO_DEN;
				else if (func == rau_pkg::FUNC_DIV && a_r == '0)
					stat_q <= rau_pkg::STAT_DIV_ZERO;
				else stat_q <= rau_pkg::STAT_OK;
			end
			rau_pkg::ST_MUL: begin
				unique case (fn_q)
					rau_pkg::FUNC_ADD, rau_pkg::FUNC_SUB: begin
						m1_s1 <= ps_m; n1_s1 <= (ps_m != '0) && (pn_q != sn_q);
						m2_s1 <= rq_m;
						n2_s1 <= (rq_m != '0) && ((rn_q != qn_q) ^ (fn_q == rau_pkg::FUNC_SUB));
						m3_s1 <= qs_m; n3_s1 <= qn_q != sn_q;
					end
					rau_pkg::FUNC_MUL: begin
						m1_s1 <= pr_m; n1_s1 <= (pr_m != '0) && (pn_q != rn_q);
						m2_s1 <= '0; n2_s1 <= 1'b0;
						m3_s1 <= qs_m; n3_s1 <= qn_q != sn_q;
					end
					default: begin
						m1_s1 <= ps_m; n1_s1 <= (ps_m != '0) && (pn_q != sn_q);
						m2_s1 <= '0; n2_s1 <= 1'b0;
						m3_s1 <= qr_m; n3_s1 <= qn_q != rn_q;
					end
				endcase
				par_q <= 1'b0;
			end
			rau_pkg::ST_GCD: begin
				if (cmp_q == 1'b0 && !dctl.busy && m3_s1 != '0) begin
					// first GCD cycle loads x,y from the cross products
					nm_q <= sum_m; nn_q <= sum_n;
					dm_q <= m3_s1; dn_q <= n3_s1;
					x_q  <= sum_m; y_q <= m3_s1;
					m3_s1 <= '0;
				end else if (dctl.done) begin
					x_q <= y_q;
					y_q <= drem;
					par_q <= ~par_q;
				end
			end
			rau_pkg::ST_DIVN: if (dctl.done) nq_q <= dquo;
			rau_pkg::ST_DIVD: if (dctl.done) begin
				rn_out_q <= to_out((nq_q != '0) && (nn_q != gneg), nq_q);
				rd_out_q <= to_out(dn_q != gneg, dquo);
			end
			default: ;
		endcase
	end

	assign in_ready           = (st_q == rau_pkg::ST_IDLE);
	assign out_valid          = ov_q;
	assign result_numerator   = rn_out_q;
	assign result_denominator = rd_out_q;
	assign status             = stat_q;
endmodule
